// ===== src/rsc_pkg.sv =====
// Package for the recursive systematic convolutional encoder.
// Holds the configuration register codes, the back-end state type and the result
// record. It has no dependencies.
package rsc_pkg;

  // Widths of the configuration port and its registers.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int POLY_W      = 16;
  localparam int KLEN_W      = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FEEDBACK_POLY     = 2'd0,
    CFG_FORWARD_POLY      = 2'd1,
    CFG_CONSTRAINT_LENGTH = 2'd2,
    CFG_TERMINATE_BLOCK   = 2'd3
  } cfg_reg_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_DATA,
    BK_TAIL_BIT,
    BK_TAIL_PAR
  } back_state_t;

  // One result item as it appears on the output side.
  typedef struct packed {
    logic code_bit;
    logic is_tail;
    logic last;
  } result_t;

  // Status reported by the back end to the top level.
  typedef struct packed {
    logic in_tail;
    logic q_pop;
  } back_status_t;

endpackage

// ===== src/rsc_encoder_with_tail_core.sv =====
// Top level of the recursive systematic convolutional encoder with tail.
// Depends on rsc_pkg, rsc_front, rsc_queue, rsc_back and rsc_step.
//
// Usage:
// Information bits enter through a queue-like port: push with info_bit and
// block_end; a request is taken at a clock edge where push is high and full low.
// Results leave through a second queue-like port: while empty is low the oldest
// result sits on code_bit, is_tail and last, and pop takes it.
// Each information bit gives one parity result. When block_end is set and
// terminate_block is 1, 2*(K-1) tail results follow (tail bit, then parity).
// Each request goes through the request queue and then the output register.
// One request per cycle is taken while full is low; a terminated block end
// holds the back end for its tail results, one per cycle while the receiver pops.
// The front end keeps taking requests meanwhile until the two-entry request
// queue fills, then raises full. When the receiver stops popping, the output
// register holds its result, the back end waits and the queue fills behind it.
// Reset clears the encoder register, the request queue, the output register and
// the back-end sequencer and loads the registers with feedback 13, forward 11,
// K = 4 and termination on. The user writes configuration through cfg_write,
// cfg_index and cfg_data only while idle; the block does not enforce this.
module rsc_encoder_with_tail_core #(
  parameter int MAX_CONSTRAINT = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           info_bit,
  input  logic                           block_end,
  output logic                           empty,
  input  logic                           pop,
  output logic                           code_bit,
  output logic                           is_tail,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int KW = MAX_CONSTRAINT;
  localparam int MW = $clog2(KW);

  logic [rsc_pkg::POLY_W-1:0] feedback_poly;
  logic [rsc_pkg::POLY_W-1:0] forward_poly;
  logic [rsc_pkg::KLEN_W-1:0] constraint_length;
  logic                       terminate_block;

  logic [MW-1:0]         mem;
  logic [KW-1:0]         top_bit;
  logic [KW-1:0]         mmask_full;
  logic [KW-1:0]         kmask;
  logic [KW-1:0]         fb;
  logic [KW-1:0]         ff;
  logic                  q_full;
  logic                  q_wr;
  logic [KW:0]           q_wdata;
  logic                  q_valid;
  logic [KW:0]           q_rdata;
  logic                  q_pop;
  rsc_pkg::result_t      res;
  rsc_pkg::back_status_t bk_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_poly     <= rsc_pkg::POLY_W'(13);
      forward_poly      <= rsc_pkg::POLY_W'(11);
      constraint_length <= rsc_pkg::KLEN_W'(4);
      terminate_block   <= 1'b1;
    end else if (cfg_write) begin
      case (rsc_pkg::cfg_reg_t'(cfg_index))
        rsc_pkg::CFG_FEEDBACK_POLY:     feedback_poly     <= cfg_data;
        rsc_pkg::CFG_FORWARD_POLY:      forward_poly      <= cfg_data;
        rsc_pkg::CFG_CONSTRAINT_LENGTH: constraint_length <= cfg_data[rsc_pkg::KLEN_W-1:0];
        rsc_pkg::CFG_TERMINATE_BLOCK:   terminate_block   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp K into range and derive the register length and tap masks.
  always_comb begin
    if (constraint_length < rsc_pkg::KLEN_W'(2)) begin
      mem = MW'(1);
    end else if (32'(constraint_length) > MAX_CONSTRAINT) begin
      mem = MW'(MAX_CONSTRAINT - 1);
    end else begin
      mem = MW'(constraint_length - rsc_pkg::KLEN_W'(1));
    end
    top_bit    = KW'(1) << mem;
    mmask_full = top_bit - KW'(1);
    kmask      = (top_bit << 1) - KW'(1);
    fb         = KW'(feedback_poly) & kmask;
    ff         = KW'(forward_poly) & kmask;
  end

  rsc_front #(.KW(KW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .info_bit (info_bit),
    .block_end(block_end),
    .full     (full),
    .terminate(terminate_block),
    .mem      (mem),
    .fb       (fb),
    .ff       (ff),
    .mmask    (mmask_full[KW-2:0]),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  rsc_queue #(.W(KW + 1)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .nonempty(q_valid)
  );

  rsc_back #(.KW(KW)) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .mem    (mem),
    .fb     (fb),
    .ff     (ff),
    .mmask  (mmask_full[KW-2:0]),
    .pop    (pop),
    .res    (res),
    .empty  (empty),
    .status (bk_status)
  );

  assign code_bit = res.code_bit;
  assign is_tail  = res.is_tail;
  assign last     = res.last;

  // A popped tail bit is always followed at once by its parity result.
  a_tail_then_parity: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && is_tail) |=> (!empty && !is_tail))
    else $error("tail bit not followed by its parity result");

  // A tail bit never closes the results of a request.
  a_tail_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_tail) |-> !last)
    else $error("tail bit marked as last");

  // While tail pairs are in progress the output register is occupied.
  a_tail_occupies_output: assert property (@(posedge clk) disable iff (rst)
    bk_status.in_tail |-> !empty)
    else $error("output register empty during tail sequence");

  // The back end only takes a request while no tail sequence is running.
  a_pop_outside_tail: assert property (@(posedge clk) disable iff (rst)
    bk_status.q_pop |-> !bk_status.in_tail)
    else $error("request taken during tail sequence");

endmodule

// ===== src/rsc_step.sv =====
// One trellis step of the encoder: feedback bit, parity bit and next register.
// Purely combinational; no package dependencies.
module rsc_step #(
  parameter int KW = 16
) (
  input  logic                   bit_in,
  input  logic [KW-2:0]          reg_in,
  input  logic [$clog2(KW)-1:0]  mem,
  input  logic [KW-1:0]          fb,
  input  logic [KW-1:0]          ff,
  output logic                   parity,
  output logic [KW-2:0]          reg_out
);

  logic [KW-1:0] top_bit;
  logic [KW-1:0] full_word;
  logic          feedback;
  logic [KW-1:0] fed_word;

  // The new bit enters at position mem, the feedback replaces it there.
  always_comb begin
    top_bit   = KW'(1) << mem;
    full_word = ({KW{bit_in}} & top_bit) | {1'b0, reg_in};
    feedback  = ^(full_word & fb);
    fed_word  = ({KW{feedback}} & top_bit) | {1'b0, reg_in};
    parity    = ^(fed_word & ff);
    reg_out   = fed_word[KW-1:1];
  end

endmodule

// ===== src/rsc_queue.sv =====
// Two-entry request queue between the front and the back end.
// Generic payload width; no package dependencies.
module rsc_queue #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         nonempty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;

  // Storage for queued requests.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/rsc_front.sv =====
// Front end: accepts information bits, runs the data trellis step and queues a
// request for the back end. Depends on rsc_step.
module rsc_front #(
  parameter int KW = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  info_bit,
  input  logic                  block_end,
  output logic                  full,
  input  logic                  terminate,
  input  logic [$clog2(KW)-1:0] mem,
  input  logic [KW-1:0]         fb,
  input  logic [KW-1:0]         ff,
  input  logic [KW-2:0]         mmask,
  input  logic                  q_full,
  output logic                  q_wr,
  output logic [KW:0]           q_data
);

  logic [KW-2:0] shift_register;
  logic [KW-2:0] reg_masked;
  logic [KW-2:0] reg_step;
  logic          parity;
  logic          accept;

  assign full       = q_full;
  assign accept     = push && !q_full;
  assign q_wr       = accept;
  assign reg_masked = shift_register & mmask;

  rsc_step #(.KW(KW)) u_step (
    .bit_in (info_bit),
    .reg_in (reg_masked),
    .mem    (mem),
    .fb     (fb),
    .ff     (ff),
    .parity (parity),
    .reg_out(reg_step)
  );

  // Request: tail flag, parity bit and the register after the data step.
  assign q_data = {block_end && terminate, parity, reg_step};

  // The encoder register restarts from zero after every block.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_register <= '0;
    end else if (accept) begin
      shift_register <= block_end ? '0 : (reg_step & mmask);
    end
  end

endmodule

// ===== src/rsc_back.sv =====
// Back end: emits the parity of each request and, for terminated blocks, the
// tail pairs, into an output register. Depends on rsc_pkg and rsc_step.
module rsc_back #(
  parameter int KW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic [KW:0]              q_data,
  output logic                     q_pop,
  input  logic [$clog2(KW)-1:0]    mem,
  input  logic [KW-1:0]            fb,
  input  logic [KW-1:0]            ff,
  input  logic [KW-2:0]            mmask,
  input  logic                     pop,
  output rsc_pkg::result_t         res,
  output logic                     empty,
  output rsc_pkg::back_status_t    status
);

  localparam int MW = $clog2(KW);

  rsc_pkg::back_state_t state;
  rsc_pkg::back_state_t state_next;
  logic                 out_valid;
  logic                 out_valid_next;
  rsc_pkg::result_t     out_res;
  rsc_pkg::result_t     out_res_next;
  logic [KW-2:0]        tail_reg;
  logic [KW-2:0]        tail_reg_next;
  logic                 pend_par;
  logic                 pend_par_next;
  logic [MW-1:0]        cnt;
  logic [MW-1:0]        cnt_next;
  logic                 adv;
  logic                 need_tail;
  logic                 q_parity;
  logic [KW-2:0]        q_reg;
  logic                 tail_bit;
  logic                 tail_par;
  logic [KW-2:0]        tail_step;
  logic                 last_pair;

  assign need_tail = q_data[KW];
  assign q_parity  = q_data[KW-1];
  assign q_reg     = q_data[KW-2:0];
  assign adv       = !out_valid || pop;
  assign last_pair = (cnt == mem - MW'(1));

  // Tail bit that forces the feedback to zero, and its trellis step.
  assign tail_bit = ^(tail_reg & fb[KW-2:0] & mmask);

  rsc_step #(.KW(KW)) u_step (
    .bit_in (tail_bit),
    .reg_in (tail_reg),
    .mem    (mem),
    .fb     (fb),
    .ff     (ff),
    .parity (tail_par),
    .reg_out(tail_step)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      rsc_pkg::BK_DATA: begin
        if (adv && q_valid && need_tail) begin
          state_next = rsc_pkg::BK_TAIL_BIT;
        end
      end
      rsc_pkg::BK_TAIL_BIT: begin
        if (adv) begin
          state_next = rsc_pkg::BK_TAIL_PAR;
        end
      end
      rsc_pkg::BK_TAIL_PAR: begin
        if (adv) begin
          state_next = last_pair ? rsc_pkg::BK_DATA : rsc_pkg::BK_TAIL_BIT;
        end
      end
      default: state_next = rsc_pkg::BK_DATA;
    endcase
  end

  // Output register, tail register and pair counter.
  always_comb begin
    q_pop          = 1'b0;
    out_valid_next = out_valid;
    out_res_next   = out_res;
    tail_reg_next  = tail_reg;
    pend_par_next  = pend_par;
    cnt_next       = cnt;
    if (adv) begin
      out_valid_next = 1'b0;
      case (state)
        rsc_pkg::BK_DATA: begin
          if (q_valid) begin
            q_pop          = 1'b1;
            out_valid_next = 1'b1;
            out_res_next   = '{code_bit: q_parity, is_tail: 1'b0, last: !need_tail};
            tail_reg_next  = q_reg;
            cnt_next       = '0;
          end
        end
        rsc_pkg::BK_TAIL_BIT: begin
          out_valid_next = 1'b1;
          out_res_next   = '{code_bit: tail_bit, is_tail: 1'b1, last: 1'b0};
          tail_reg_next  = tail_step;
          pend_par_next  = tail_par;
        end
        rsc_pkg::BK_TAIL_PAR: begin
          out_valid_next = 1'b1;
          out_res_next   = '{code_bit: pend_par, is_tail: 1'b0, last: last_pair};
          cnt_next       = cnt + MW'(1);
        end
        default: out_valid_next = 1'b0;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rsc_pkg::BK_DATA;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_res  <= out_res_next;
    tail_reg <= tail_reg_next;
    pend_par <= pend_par_next;
  end

  assign res            = out_res;
  assign empty          = !out_valid;
  assign status.in_tail = (state != rsc_pkg::BK_DATA);
  assign status.q_pop   = q_pop;

endmodule
